// File: src/fsbp_pkg.sv
package fsbp_pkg;

    // Default sizing, handed to the top level parameters
    localparam int DEF_NUM_BUCKETS  = 8;
    localparam int DEF_EXCESS_WIDTH = 48;

    // Fixed field widths
    localparam int MASK_W   = 8;
    localparam int TICKS_W  = 32;
    localparam int INDEX_W  = 3;
    localparam int STATUS_W = 2;

    // Stream word layouts
    localparam int S_TDATA_W = MASK_W + TICKS_W;
    localparam int M_TDATA_W = 8;
    localparam int M_USED_W  = 1 + INDEX_W + STATUS_W;

    // Command carried in the slave tuser
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_END   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_NONE = 2'd1,
        STATUS_BUSY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SUB,
        S_ADD,
        S_DONE
    } state_t;

endpackage

// File: src/fair_share_bucket_picker.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: cmd; tdata: mask, elapsed ticks
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: granted, bucket index, status
//
// One word is taken at a time; s_axis_tready is high only while the sequencer is idle.
// A granted begin scans the first min(NUM_BUCKETS, 8) counters with one shared adder to
// find the least excess, then walks all NUM_BUCKETS counters to subtract it. A begin with
// no ready bucket ends after the scan; a begin while busy or an end while idle goes straight
// to the result. A stalled m_axis only holds the final step, since the result sits in an
// output register; rst_n clears all counters, busy and the current bucket.
module fair_share_bucket_picker #(
    parameter int NUM_BUCKETS  = fsbp_pkg::DEF_NUM_BUCKETS,
    parameter int EXCESS_WIDTH = fsbp_pkg::DEF_EXCESS_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] nonempty_mask, [39:8] elapsed_ticks
    input  logic [fsbp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] cmd
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] granted, [3:1] bucket_index, [5:4] status, [7:6] zero
    output logic [fsbp_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W     = $clog2(NUM_BUCKETS);
    localparam int SCAN_N    = (NUM_BUCKETS < fsbp_pkg::MASK_W) ? NUM_BUCKETS
                                                                : fsbp_pkg::MASK_W;
    localparam int OP_W      = (EXCESS_WIDTH > fsbp_pkg::TICKS_W) ? EXCESS_WIDTH
                                                                  : fsbp_pkg::TICKS_W;
    localparam int SUM_W     = OP_W + 1;
    localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(SCAN_N - 1);
    localparam logic [IDX_W-1:0] SUB_LAST  = IDX_W'(NUM_BUCKETS - 1);
    localparam logic [SUM_W-1:0] EXCESS_MAX_EXT = SUM_W'({EXCESS_WIDTH{1'b1}});

    fsbp_pkg::state_t state_reg, state_next;

    logic [EXCESS_WIDTH-1:0]        excess_reg [NUM_BUCKETS];
    logic [EXCESS_WIDTH-1:0]        excess_next;
    logic                           excess_we;

    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [fsbp_pkg::MASK_W-1:0]    mask_reg, mask_next;
    logic [fsbp_pkg::TICKS_W-1:0]   ticks_reg, ticks_next;
    logic [EXCESS_WIDTH-1:0]        best_reg, best_next;
    logic [IDX_W-1:0]               pick_reg, pick_next;
    logic                           found_reg, found_next;
    logic                           busy_reg, busy_next;
    logic [fsbp_pkg::INDEX_W-1:0]   cur_reg, cur_next;

    logic                           res_granted_reg, res_granted_next;
    logic [fsbp_pkg::INDEX_W-1:0]   res_index_reg, res_index_next;
    fsbp_pkg::status_t              res_status_reg, res_status_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           out_granted_reg, out_granted_next;
    logic [fsbp_pkg::INDEX_W-1:0]   out_index_reg, out_index_next;
    fsbp_pkg::status_t              out_status_reg, out_status_next;

    logic                           s_accept;
    logic [IDX_W-1:0]               cur_idx;
    logic [IDX_W-1:0]               rd_idx;
    logic                           is_add;
    logic [OP_W-1:0]                op_a;
    logic [OP_W-1:0]                op_b;
    logic [SUM_W-1:0]               sum;
    logic                           a_below_b;
    logic                           mask_bit;

    assign s_axis_tready = (state_reg == fsbp_pkg::S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(fsbp_pkg::M_TDATA_W - fsbp_pkg::M_USED_W)'(0),
                            out_status_reg, out_index_reg, out_granted_reg};

    // Shared adder: subtract during scan and floor pass, add on end
    assign cur_idx   = IDX_W'(cur_reg);
    assign is_add    = (state_reg == fsbp_pkg::S_ADD);
    assign rd_idx    = is_add ? cur_idx : idx_reg;
    assign op_a      = OP_W'(excess_reg[rd_idx]);
    assign op_b      = is_add ? OP_W'(ticks_reg) : ~OP_W'(best_reg);
    assign sum       = {1'b0, op_a} + {1'b0, op_b} + SUM_W'(!is_add);
    assign a_below_b = !sum[OP_W];
    assign mask_bit  = mask_reg[3'(idx_reg)];

    // Sequencer: next state, datapath updates and result
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        mask_next        = mask_reg;
        ticks_next       = ticks_reg;
        best_next        = best_reg;
        pick_next        = pick_reg;
        found_next       = found_reg;
        busy_next        = busy_reg;
        cur_next         = cur_reg;
        res_granted_next = res_granted_reg;
        res_index_next   = res_index_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg;
        out_granted_next = out_granted_reg;
        out_index_next   = out_index_reg;
        out_status_next  = out_status_reg;
        excess_we        = 1'b0;
        excess_next      = sum[EXCESS_WIDTH-1:0];

        // Drop the output word once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            fsbp_pkg::S_IDLE:
            begin
                if (s_accept)
                begin
                    mask_next  = s_axis_tdata[fsbp_pkg::MASK_W-1:0];
                    ticks_next = s_axis_tdata[fsbp_pkg::S_TDATA_W-1:fsbp_pkg::MASK_W];
                    idx_next   = '0;
                    found_next = 1'b0;
                    if (s_axis_tuser == fsbp_pkg::CMD_BEGIN)
                    begin
                        if (busy_reg)
                        begin
                            res_granted_next = 1'b0;
                            res_index_next   = cur_reg;
                            res_status_next  = fsbp_pkg::STATUS_BUSY;
                            state_next       = fsbp_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = fsbp_pkg::S_SCAN;
                        end
                    end
                    else if (busy_reg)
                    begin
                        state_next = fsbp_pkg::S_ADD;
                    end
                    else
                    begin
                        res_granted_next = 1'b0;
                        res_index_next   = '0;
                        res_status_next  = fsbp_pkg::STATUS_NONE;
                        state_next       = fsbp_pkg::S_DONE;
                    end
                end
            end

            fsbp_pkg::S_SCAN:
            begin
                // Keep the lowest-index bucket with the least excess
                if (mask_bit && (!found_reg || a_below_b))
                begin
                    best_next  = excess_reg[idx_reg];
                    pick_next  = idx_reg;
                    found_next = 1'b1;
                end
                if (idx_reg == SCAN_LAST)
                begin
                    idx_next = '0;
                    if (found_next)
                    begin
                        state_next = fsbp_pkg::S_SUB;
                    end
                    else
                    begin
                        res_granted_next = 1'b0;
                        res_index_next   = '0;
                        res_status_next  = fsbp_pkg::STATUS_NONE;
                        state_next       = fsbp_pkg::S_DONE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            fsbp_pkg::S_SUB:
            begin
                // Subtract the least excess, floor at zero
                excess_we   = 1'b1;
                excess_next = a_below_b ? '0 : sum[EXCESS_WIDTH-1:0];
                if (idx_reg == SUB_LAST)
                begin
                    busy_next        = 1'b1;
                    cur_next         = fsbp_pkg::INDEX_W'(pick_reg);
                    res_granted_next = 1'b1;
                    res_index_next   = fsbp_pkg::INDEX_W'(pick_reg);
                    res_status_next  = fsbp_pkg::STATUS_OK;
                    state_next       = fsbp_pkg::S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            fsbp_pkg::S_ADD:
            begin
                // Charge the run time, saturating
                excess_we        = 1'b1;
                excess_next      = (sum > EXCESS_MAX_EXT) ? {EXCESS_WIDTH{1'b1}}
                                                          : sum[EXCESS_WIDTH-1:0];
                busy_next        = 1'b0;
                res_granted_next = 1'b1;
                res_index_next   = cur_reg;
                res_status_next  = fsbp_pkg::STATUS_OK;
                state_next       = fsbp_pkg::S_DONE;
            end

            fsbp_pkg::S_DONE:
            begin
                // Hand the result over when the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_index_next   = res_index_reg;
                    out_status_next  = res_status_reg;
                    state_next       = fsbp_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fsbp_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fsbp_pkg::S_IDLE;
            busy_reg      <= 1'b0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
        end
    end

    // Excess counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                excess_reg[i] <= '0;
            end
        end
        else if (excess_we)
        begin
            excess_reg[rd_idx] <= excess_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mask_reg        <= mask_next;
        ticks_reg       <= ticks_next;
        best_reg        <= best_next;
        pick_reg        <= pick_next;
        res_granted_reg <= res_granted_next;
        res_index_reg   <= res_index_next;
        res_status_reg  <= res_status_next;
        out_granted_reg <= out_granted_next;
        out_index_reg   <= out_index_next;
        out_status_reg  <= out_status_next;
    end

    // A granted word always carries an ok status
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_granted_reg) |-> (out_status_reg == fsbp_pkg::STATUS_OK))
        else $error("granted word without ok status");

    // Busy is only set at the end of the floor pass
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(state_reg == fsbp_pkg::S_SUB))
        else $error("busy set outside the floor pass");

    // An accepted word leaves the idle state
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg != fsbp_pkg::S_IDLE))
        else $error("sequencer stayed idle after accept");

    // The walking index stays inside the counter array
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == fsbp_pkg::S_SCAN) || (state_reg == fsbp_pkg::S_SUB))
            |-> (idx_reg <= SUB_LAST))
        else $error("bucket index out of range");

endmodule

// File: sim/tb_fair_share_bucket_picker.sv
`timescale 1ns / 100ps

module tb_fair_share_bucket_picker;

    localparam int NB          = fsbp_pkg::DEF_NUM_BUCKETS;
    localparam int EXW         = fsbp_pkg::DEF_EXCESS_WIDTH;
    localparam int NUM_ROWS    = 24;
    localparam int RANDOM_WORDS = 800;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LOG_DEPTH   = 2048;

    // Result word as the block should produce it
    typedef struct packed {
        logic               granted;
        logic [2:0]         bucket;
        fsbp_pkg::status_t  status;
    } grant_word_t;

    // One directed stimulus word, with an optional hand-written expectation
    typedef struct packed {
        logic          cmd;
        logic [7:0]    mask;
        logic [31:0]   ticks;
        logic          typed;
        grant_word_t   want;
    } stim_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [fsbp_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [fsbp_pkg::M_TDATA_W-1:0] m_axis_tdata;

    // Predictor state: per-bucket excess service, busy flag, running bucket
    logic [EXW-1:0] service_excess [NB];
    logic           run_active;
    logic [2:0]     run_bucket;

    // Expected result words, in order, with write and read counts
    grant_word_t pending_grants [LOG_DEPTH];
    int grant_wr = 0;
    int grant_rd = 0;
    int mismatches = 0;
    int grants_seen = 0;
    int cycle_count = 0;
    int words_sent = 0;
    bit idle_on = 1'b1;
    bit long_hold_req = 1'b0;

    stim_row_t directed_rows [NUM_ROWS] = '{
        '{fsbp_pkg::CMD_END,   8'h00, 32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, fsbp_pkg::STATUS_NONE}},
        '{fsbp_pkg::CMD_BEGIN, 8'h00, 32'h0000_0000, 1'b1, '{1'b0, 3'd0, fsbp_pkg::STATUS_NONE}},
        '{fsbp_pkg::CMD_BEGIN, 8'hFF, 32'h0000_0000, 1'b1, '{1'b1, 3'd0, fsbp_pkg::STATUS_OK}},
        '{fsbp_pkg::CMD_BEGIN, 8'h80, 32'h0000_0000, 1'b1, '{1'b0, 3'd0, fsbp_pkg::STATUS_BUSY}},
        '{fsbp_pkg::CMD_END,   8'h00, 32'hFFFF_FFFF, 1'b1, '{1'b1, 3'd0, fsbp_pkg::STATUS_OK}},
        '{fsbp_pkg::CMD_BEGIN, 8'h01, 32'h0000_0000, 1'b1, '{1'b1, 3'd0, fsbp_pkg::STATUS_OK}},
        '{fsbp_pkg::CMD_END,   8'hFF, 32'h0000_0000, 1'b1, '{1'b1, 3'd0, fsbp_pkg::STATUS_OK}},
        '{fsbp_pkg::CMD_BEGIN, 8'h80, 32'hFFFF_FFFF, 1'b1, '{1'b1, 3'd7, fsbp_pkg::STATUS_OK}},
        '{fsbp_pkg::CMD_BEGIN, 8'hFF, 32'h0000_0000, 1'b1, '{1'b0, 3'd7, fsbp_pkg::STATUS_BUSY}},
        '{fsbp_pkg::CMD_END,   8'h00, 32'd100,       1'b1, '{1'b1, 3'd7, fsbp_pkg::STATUS_OK}},
        '{fsbp_pkg::CMD_BEGIN, 8'h81, 32'h0000_0000, 1'b0, '0},
        '{fsbp_pkg::CMD_END,   8'h00, 32'd50,        1'b0, '0},
        '{fsbp_pkg::CMD_BEGIN, 8'h81, 32'h0000_0000, 1'b0, '0},
        '{fsbp_pkg::CMD_END,   8'h00, 32'd60,        1'b0, '0},
        '{fsbp_pkg::CMD_BEGIN, 8'h81, 32'h0000_0000, 1'b0, '0},
        '{fsbp_pkg::CMD_END,   8'h00, 32'h5555_5555, 1'b0, '0},
        '{fsbp_pkg::CMD_END,   8'hFF, 32'hAAAA_AAAA, 1'b1, '{1'b0, 3'd0, fsbp_pkg::STATUS_NONE}},
        '{fsbp_pkg::CMD_BEGIN, 8'h00, 32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, fsbp_pkg::STATUS_NONE}},
        '{fsbp_pkg::CMD_BEGIN, 8'h55, 32'h0000_0000, 1'b0, '0},
        '{fsbp_pkg::CMD_END,   8'h00, 32'd1,         1'b0, '0},
        '{fsbp_pkg::CMD_BEGIN, 8'hAA, 32'h0000_0000, 1'b0, '0},
        '{fsbp_pkg::CMD_END,   8'h00, 32'h0000_FFFF, 1'b0, '0},
        '{fsbp_pkg::CMD_BEGIN, 8'hFE, 32'h0000_0000, 1'b0, '0},
        '{fsbp_pkg::CMD_END,   8'h00, 32'hFFFF_0000, 1'b0, '0}
    };

    fair_share_bucket_picker DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Grant the least-served ready bucket, or charge the running one; else report busy or none
    function automatic grant_word_t schedule_step(logic cmd, logic [7:0] mask,
                                                  logic [31:0] ticks);
        grant_word_t    r;
        logic           found;
        logic [2:0]     pick;
        logic [EXW-1:0] least;
        logic [EXW:0]   total;
        r = '{1'b0, 3'd0, fsbp_pkg::STATUS_NONE};
        if (cmd == fsbp_pkg::CMD_BEGIN)
        begin
            if (run_active)
            begin
                r.bucket = run_bucket;
                r.status = fsbp_pkg::STATUS_BUSY;
            end
            else
            begin
                found = 1'b0;
                pick  = 3'd0;
                least = '0;
                for (int i = 0; i < NB && i < fsbp_pkg::MASK_W; i++)
                begin
                    if (mask[i] && (!found || service_excess[i] < least))
                    begin
                        found = 1'b1;
                        least = service_excess[i];
                        pick  = 3'(i);
                    end
                end
                if (found)
                begin
                    // Shift every counter down by the winner's excess, floor at zero
                    for (int i = 0; i < NB; i++)
                        service_excess[i] = (service_excess[i] > least) ?
                                            service_excess[i] - least : '0;
                    run_active = 1'b1;
                    run_bucket = pick;
                    r = '{1'b1, pick, fsbp_pkg::STATUS_OK};
                end
            end
        end
        else if (run_active)
        begin
            // Charge the run time, saturating at the counter width
            total = {1'b0, service_excess[run_bucket]} + (EXW+1)'(ticks);
            service_excess[run_bucket] = total[EXW] ? '1 : total[EXW-1:0];
            run_active = 1'b0;
            r = '{1'b1, run_bucket, fsbp_pkg::STATUS_OK};
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_ticks();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [7:0] pick_mask();
        if ($urandom_range(0, 4) == 0)
            return 8'h01 << $urandom_range(0, 7);
        return 8'($urandom_range(1, 255));
    endfunction

    // Append one expected result word
    function automatic void log_grant(grant_word_t w);
        pending_grants[grant_wr % LOG_DEPTH] = w;
        grant_wr++;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t grant %0d: %s", $realtime, grants_seen, what);
        mismatches++;
    endtask

    // Offer one word, hold it until taken, then record what it should produce
    task automatic send_word(input logic cmd, input logic [7:0] mask,
                             input logic [31:0] ticks, input logic typed,
                             input grant_word_t want);
        grant_word_t predicted;
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {ticks, mask};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = schedule_step(cmd, mask, ticks);
        log_grant(typed ? want : predicted);
        words_sent++;
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_cnt;
        int gap;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                m_axis_tready <= 1'b0;
                for (hold_cnt = 1; hold_cnt < LONG_HOLD; hold_cnt++)
                    @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 7);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each result word with the oldest expectation; watchdog
    always @(posedge clk)
    begin
        grant_word_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, grant_wr - grant_rd);
            $display("tb_fair_share_bucket_picker failed");
            $finish;
        end
        else if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (grant_wr == grant_rd)
                report_mismatch($sformatf("unexpected result word %02h", m_axis_tdata));
            else
            begin
                want = pending_grants[grant_rd % LOG_DEPTH];
                grant_rd++;
                if (m_axis_tdata[0] !== want.granted)
                    report_mismatch($sformatf("granted %0b, want %0b",
                                              m_axis_tdata[0], want.granted));
                if (m_axis_tdata[3:1] !== want.bucket)
                    report_mismatch($sformatf("bucket %0d, want %0d",
                                              m_axis_tdata[3:1], want.bucket));
                if (m_axis_tdata[5:4] !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_axis_tdata[5:4], want.status));
                if (m_axis_tdata[7:6] !== 2'b00)
                    report_mismatch($sformatf("pad bits %0b, want 00", m_axis_tdata[7:6]));
            end
            grants_seen++;
        end
    end

    initial
    begin
        int random_base;
        bit hold_issued;
        for (int i = 0; i < NB; i++)
            service_excess[i] = '0;
        run_active  = 1'b0;
        run_bucket  = 3'd0;
        hold_issued = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows
        foreach (directed_rows[r])
            send_word(directed_rows[r].cmd, directed_rows[r].mask, directed_rows[r].ticks,
                      directed_rows[r].typed, directed_rows[r].want);

        // Random part: mostly begin/end pairs, some noise words
        random_base = words_sent;
        while (words_sent - random_base < RANDOM_WORDS)
        begin
            idle_on = !((words_sent - random_base) inside {[250:350]}) &&
                      (words_sent - random_base) < 650;
            if (!hold_issued && (words_sent - random_base) >= 450)
            begin
                long_hold_req = 1'b1;
                hold_issued   = 1'b1;
            end
            if ($urandom_range(0, 9) < 8)
            begin
                if (run_active)
                    send_word(fsbp_pkg::CMD_END, 8'($urandom), pick_ticks(), 1'b0, '0);
                send_word(fsbp_pkg::CMD_BEGIN, pick_mask(), $urandom, 1'b0, '0);
                send_word(fsbp_pkg::CMD_END, 8'($urandom), pick_ticks(), 1'b0, '0);
            end
            else
                send_word(1'($urandom), 8'($urandom_range(0, 1) ? $urandom : 0),
                          pick_ticks(), 1'b0, '0);
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // Drain, then allow the tail latency
        while (grant_wr != grant_rd)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb_fair_share_bucket_picker passed");
        else
            $display("tb_fair_share_bucket_picker failed");
        $finish;
    end

endmodule
